@@ design/dmsrc_pkg.sv @@
// Shared types and constants for the direct-mapped search result cache.
`timescale 1ns / 1ps

package dmsrc_pkg;

    // Table size; must be a power of two (slot index is the low key bits).
    localparam int unsigned TABLE_ENTRIES_DEF = 4096;

    localparam logic [1:0] CMD_STORE = 2'd0;
    localparam logic [1:0] CMD_PROBE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] KIND_EXACT = 2'd0;
    localparam logic [1:0] KIND_LOWER = 2'd1;
    localparam logic [1:0] KIND_UPPER = 2'd2;

    localparam logic signed [7:0] MOVE_NONE = -8'sd1;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [63:0]        key;
        logic signed [15:0] score_in;
        logic signed [7:0]  search_depth;
        logic [1:0]         bound_kind;
        logic signed [7:0]  move_in;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } in_item_t;

    typedef struct packed {
        logic               key_match;
        logic               usable;
        logic signed [15:0] score_out;
        logic signed [7:0]  move_out;
    } out_item_t;

    typedef struct packed {
        logic [63:0]        key;
        logic signed [15:0] score;
        logic signed [7:0]  depth;
        logic [1:0]         kind;
        logic signed [7:0]  move;
    } entry_t;

    typedef struct packed {
        logic [63:0]        key;
        logic signed [7:0]  search_depth;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } probe_req_t;

    localparam entry_t ENTRY_CLEARED = '{
        key:   64'd0,
        score: 16'sd0,
        depth: 8'sd0,
        kind:  KIND_EXACT,
        move:  MOVE_NONE
    };

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } ctrl_state_t;

endpackage

@@ design/dmsrc_mem.sv @@
// Slot memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module dmsrc_mem #(
    parameter int unsigned TABLE_ENTRIES = dmsrc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
    input  dmsrc_pkg::entry_t                wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
    output dmsrc_pkg::entry_t                rd_data
);
    import dmsrc_pkg::*;

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/dmsrc_eval.sv @@
// Probe evaluation: key match, depth check and bound test against the window.
`timescale 1ns / 1ps

module dmsrc_eval (
    input  dmsrc_pkg::probe_req_t req,
    input  dmsrc_pkg::entry_t     entry,
    output dmsrc_pkg::out_item_t  result
);
    import dmsrc_pkg::*;

    logic match;
    logic deep_enough;
    logic bound_ok;

    assign match       = (entry.key == req.key);
    assign deep_enough = (entry.depth >= req.search_depth);

    always_comb begin
        case (entry.kind)
            KIND_EXACT: bound_ok = 1'b1;
            KIND_LOWER: bound_ok = (entry.score >= req.beta);
            KIND_UPPER: bound_ok = (entry.score <= req.alpha);
            default:    bound_ok = 1'b0;
        endcase
    end

    always_comb begin
        result.key_match = match;
        result.usable    = match && deep_enough && bound_ok;
        result.score_out = result.usable ? entry.score : 16'sd0;
        result.move_out  = match ? entry.move : MOVE_NONE;
    end

endmodule

@@ design/direct_mapped_search_result_cache_top.sv @@
// Top level of the direct-mapped search result cache (always-replace table).
`timescale 1ns / 1ps

// Usage:
//   s_ channel takes commands: store, probe or clear (code 3 is dropped).
//   m_ channel returns one result per probe; stores and clears return none.
//   A store writes its slot (low key bits) on the transfer edge, so a probe in
//   the very next cycle already sees it.
//   Probe path: the slot read and the request are registered on the transfer
//   edge, then the evaluated result is captured in the output register.
//   Throughput: one command per cycle while s_ready is high; a store uses the
//   write port and a probe uses the read port.
//   Clear and reset: the table is swept one slot per cycle, all TABLE_ENTRIES
//   slots (4096 by default); s_ready stays low during the sweep. A probe
//   already in flight still completes.
//   Receiver stall: the output register holds the result, the probe in the
//   read stage waits behind it, and s_ready drops only when both are full.
//   TABLE_ENTRIES must be a power of two.
module direct_mapped_search_result_cache_top #(
    parameter int unsigned TABLE_ENTRIES = dmsrc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dmsrc_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dmsrc_pkg::out_item_t m_data
);
    import dmsrc_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    ctrl_state_t state_reg, state_next;
    logic [IDX_W-1:0] clr_ptr_reg, clr_ptr_next;

    logic       a_valid_reg;
    probe_req_t a_req_reg;
    logic       m_valid_reg;
    out_item_t  m_data_reg;

    logic       s_fire;
    logic       a_adv;
    logic       a_free;
    logic       is_store;
    logic       is_probe;
    logic       is_clear;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    entry_t           rd_data;
    out_item_t        eval_result;
    probe_req_t       new_req;

    assign a_adv   = !m_valid_reg || m_ready;
    assign a_free  = !a_valid_reg || a_adv;
    assign s_ready = (state_reg == ST_RUN) && a_free;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        is_store = 1'b0;
        is_probe = 1'b0;
        is_clear = 1'b0;
        unique case (s_data.cmd)
            CMD_STORE: is_store = 1'b1;
            CMD_PROBE: is_probe = 1'b1;
            CMD_CLEAR: is_clear = 1'b1;
            default: begin
            end
        endcase
    end

    // Controller: clear sweep and memory write port selection.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_ptr_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_ptr_reg <= clr_ptr_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_ptr_next = clr_ptr_reg;
        wr_en        = 1'b0;
        wr_addr      = s_data.key[IDX_W-1:0];
        wr_data      = '{
            key:   s_data.key,
            score: s_data.score_in,
            depth: s_data.search_depth,
            kind:  s_data.bound_kind,
            move:  s_data.move_in
        };
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_ptr_reg;
                wr_data      = ENTRY_CLEARED;
                clr_ptr_next = clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == LAST_IDX) begin
                    state_next   = ST_RUN;
                    clr_ptr_next = '0;
                end
            end
            ST_RUN: begin
                wr_en = s_fire && is_store;
                if (s_fire && is_clear) begin
                    state_next   = ST_CLEAR;
                    clr_ptr_next = '0;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    dmsrc_mem #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (s_fire && is_probe),
        .rd_addr (s_data.key[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Read stage: probe request waits here alongside the memory read data.
    assign new_req = '{
        key:          s_data.key,
        search_depth: s_data.search_depth,
        alpha:        s_data.alpha,
        beta:         s_data.beta
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_fire && is_probe) begin
            a_valid_reg <= 1'b1;
        end else if (a_adv) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && is_probe) begin
            a_req_reg <= new_req;
        end
    end

    dmsrc_eval u_eval (
        .req    (a_req_reg),
        .entry  (rd_data),
        .result (eval_result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_valid_reg && a_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg && a_adv) begin
            m_data_reg <= eval_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ dv/direct_mapped_search_result_cache_top_test.sv @@
// Self-checking testbench for the direct-mapped search result cache top level.
`timescale 1ns / 1ps

module direct_mapped_search_result_cache_top_test;
    import dmsrc_pkg::*;

    localparam int unsigned SLOTS = TABLE_ENTRIES_DEF;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 650;
    localparam int QUIET_TAIL = 80;
    localparam int KEY_POOL_MAX = 24;

    // Codes with no name in the package.
    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam logic [1:0] KIND_UNDEF = 2'd3;

    localparam logic [63:0] K_TOP = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] K_LOW = 64'h8000_0000_0000_0005;
    localparam logic [63:0] K_UP = 64'h0123_4567_89AB_C007;
    localparam logic [63:0] K_UP_ALIAS = 64'hFEDC_0000_0000_0007;
    localparam logic [63:0] K_ODD = 64'h5A5A_0000_0000_0ABC;

    // Mirror of the table plus the queue of probe results still owed.
    class probe_scoreboard;
        entry_t    slots [SLOTS];
        out_item_t expected_q [$];
        int        errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (slots[i]) slots[i] = ENTRY_CLEARED;
        endfunction

        function void note_input(in_item_t it);
            logic [IDX_W-1:0] idx;
            entry_t           e;
            out_item_t        r;
            idx = it.key[IDX_W-1:0];
            e = slots[idx];
            case (it.cmd)
                CMD_STORE: begin
                    slots[idx] = '{key: it.key, score: it.score_in, depth: it.search_depth,
                                   kind: it.bound_kind, move: it.move_in};
                end
                CMD_PROBE: begin
                    r = '{key_match: 1'b0, usable: 1'b0, score_out: 16'sd0,
                          move_out: MOVE_NONE};
                    if (e.key == it.key) begin
                        r.key_match = 1'b1;
                        r.move_out = e.move;
                        if (e.depth >= it.search_depth &&
                            (e.kind == KIND_EXACT ||
                             (e.kind == KIND_LOWER && e.score >= it.beta) ||
                             (e.kind == KIND_UPPER && e.score <= it.alpha))) begin
                            r.usable = 1'b1;
                            r.score_out = e.score;
                        end
                    end
                    expected_q.push_back(r);
                end
                CMD_CLEAR: begin
                    wipe();
                end
                default: ;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result: match=%0b usable=%0b score=%0d move=%0d",
                             got.key_match, got.usable, got.score_out, got.move_out);
                return;
            end
            want = expected_q.pop_front();
            if (got.key_match !== want.key_match || got.usable !== want.usable ||
                got.score_out !== want.score_out || got.move_out !== want.move_out) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: probe mismatch: exp match=%0b usable=%0b score=%0d move=%0d",
                             want.key_match, want.usable, want.score_out, want.move_out);
                    $display("                       got match=%0b usable=%0b score=%0d move=%0d",
                             got.key_match, got.usable, got.score_out, got.move_out);
                end
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    probe_scoreboard sb;
    bit              quiet;
    int              idle_cycles = 0;
    int              clears_left = 4;
    logic [63:0]     key_pool [$];

    direct_mapped_search_result_cache_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Transfer monitor and watchdog; a clear sweep stalls the input, so IDLE_LIMIT must cover it.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && s_valid && s_ready === 1'b1)
            sb.note_input(s_data);
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready)
            sb.check_result(m_data);
        if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver backpressure: phases of different stall density, with random stall bursts.
    initial begin
        int stall_left;
        int phase_left;
        int odds;
        stall_left = 0;
        phase_left = 0;
        odds = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (phase_left == 0) begin
                phase_left = 100;
                odds = $urandom_range(0, 2);
            end
            phase_left--;
            if (quiet) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (odds != 0 && $urandom_range(0, odds * 4) == 0) begin
                stall_left = $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic in_item_t mk(logic [1:0] cmd, logic [63:0] k,
                                    logic signed [15:0] score, logic signed [7:0] depth,
                                    logic [1:0] kind, logic signed [7:0] move,
                                    logic signed [15:0] lo, logic signed [15:0] hi);
        return '{cmd, k, score, depth, kind, move, lo, hi};
    endfunction

    // Mostly stores and probes on recently stored keys, with aliases and noise.
    function automatic in_item_t random_cmd();
        int                 pick;
        int                 key_mode;
        logic [63:0]        k;
        logic [63:0]        pooled;
        logic [1:0]         cmd;
        logic [1:0]         kind;
        logic signed [15:0] score;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            cmd = CMD_STORE;
        else if (pick < 96)
            cmd = CMD_PROBE;
        else if (pick < 98)
            cmd = CMD_NOP;
        else if (clears_left > 0) begin
            cmd = CMD_CLEAR;
            clears_left--;
        end else
            cmd = CMD_PROBE;

        pooled = (key_pool.size() != 0) ? key_pool[$urandom_range(0, key_pool.size() - 1)]
                                        : {$urandom, $urandom};
        key_mode = $urandom_range(0, 9);
        k = {$urandom, $urandom};
        if (key_mode >= 2 && key_mode <= 7)
            k = pooled;
        else if (key_mode == 8)
            k[IDX_W-1:0] = pooled[IDX_W-1:0];
        else if (key_mode == 9)
            k = 64'd0;

        score = 16'($urandom);
        if ($urandom_range(0, 7) == 0)
            score = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;

        case ($urandom_range(0, 15))
            0:       kind = KIND_UNDEF;
            1, 2, 3, 4, 5: kind = KIND_EXACT;
            6, 7, 8, 9, 10: kind = KIND_LOWER;
            default: kind = KIND_UPPER;
        endcase

        if (cmd == CMD_STORE) begin
            key_pool.push_back(k);
            if (key_pool.size() > KEY_POOL_MAX)
                void'(key_pool.pop_front());
        end
        return mk(cmd, k, score, 8'($urandom), kind, 8'($urandom),
                  16'($urandom), 16'($urandom));
    endfunction

    // Entered and left at a falling edge; valid holds until the transfer.
    task automatic push_cmd(input in_item_t it);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
    endtask

    initial begin
        int sent;
        in_item_t it;
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        quiet = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Cleared table: key 0 hits slot 0, score 0 usable only at depth <= 0.
        push_cmd(mk(CMD_PROBE, 64'd0, 16'sd0, 8'sd0, KIND_EXACT, 8'sd0, 16'sd0, 16'sd0));
        push_cmd(mk(CMD_PROBE, 64'd0, 16'sd0, 8'sd1, KIND_EXACT, 8'sd0, 16'sd0, 16'sd0));
        push_cmd(mk(CMD_PROBE, 64'd0, 16'sd0, -8'sd128, KIND_EXACT, 8'sd0, 16'sd0, 16'sd0));
        push_cmd(mk(CMD_PROBE, K_TOP, 16'sd0, 8'sd0, KIND_EXACT, 8'sd0, 16'sd0, 16'sd0));
        // Field extremes, exact entry.
        push_cmd(mk(CMD_STORE, K_TOP, 16'sh7FFF, 8'sd127, KIND_EXACT, 8'sd127,
                    16'sd0, 16'sd0));
        push_cmd(mk(CMD_PROBE, K_TOP, 16'sd0, 8'sd127, KIND_EXACT, 8'sd0,
                    16'sh8000, 16'sh7FFF));
        push_cmd(mk(CMD_PROBE, K_TOP, 16'sd0, -8'sd128, KIND_EXACT, 8'sd0,
                    16'sh7FFF, 16'sh8000));
        // Lower bound at the bottom of the ranges.
        push_cmd(mk(CMD_STORE, K_LOW, 16'sh8000, -8'sd128, KIND_LOWER, -8'sd128,
                    16'sd0, 16'sd0));
        push_cmd(mk(CMD_PROBE, K_LOW, 16'sd0, -8'sd128, KIND_EXACT, 8'sd0,
                    16'sd0, 16'sh8000));
        push_cmd(mk(CMD_PROBE, K_LOW, 16'sd0, -8'sd128, KIND_EXACT, 8'sd0,
                    16'sd0, 16'sh8001));
        push_cmd(mk(CMD_PROBE, K_LOW, 16'sd0, -8'sd127, KIND_EXACT, 8'sd0,
                    16'sd0, 16'sh8000));
        // Upper bound: alpha on the edge, one below, depth one too deep.
        push_cmd(mk(CMD_STORE, K_UP, 16'sd100, 8'sd5, KIND_UPPER, 8'sd0, 16'sd0, 16'sd0));
        push_cmd(mk(CMD_PROBE, K_UP, 16'sd0, 8'sd5, KIND_EXACT, 8'sd0, 16'sd100, 16'sd0));
        push_cmd(mk(CMD_PROBE, K_UP, 16'sd0, 8'sd5, KIND_EXACT, 8'sd0, 16'sd99, 16'sd0));
        push_cmd(mk(CMD_PROBE, K_UP, 16'sd0, 8'sd6, KIND_EXACT, 8'sd0, 16'sd100, 16'sd0));
        // Undefined bound kind: matches but is never usable.
        push_cmd(mk(CMD_STORE, K_ODD, 16'sd7, 8'sd0, KIND_UNDEF, 8'sd3, 16'sd0, 16'sd0));
        push_cmd(mk(CMD_PROBE, K_ODD, 16'sd0, -8'sd128, KIND_EXACT, 8'sd0,
                    16'sh7FFF, 16'sh8000));
        // Unknown command must leave the slot alone.
        push_cmd(mk(CMD_NOP, K_UP, -16'sd5, -8'sd1, KIND_EXACT, -8'sd1, 16'sd0, 16'sd0));
        push_cmd(mk(CMD_PROBE, K_UP, 16'sd0, 8'sd0, KIND_EXACT, 8'sd0, 16'sd100, 16'sd0));
        // Same slot, different upper key bits.
        push_cmd(mk(CMD_PROBE, K_UP_ALIAS, 16'sd0, 8'sd0, KIND_EXACT, 8'sd0,
                    16'sd100, 16'sd0));
        // Clear, then old key misses and key 0 hits again.
        push_cmd(mk(CMD_CLEAR, 64'd0, 16'sd0, 8'sd0, KIND_EXACT, 8'sd0, 16'sd0, 16'sd0));
        push_cmd(mk(CMD_PROBE, K_UP, 16'sd0, 8'sd0, KIND_EXACT, 8'sd0, 16'sd100, 16'sd0));
        push_cmd(mk(CMD_PROBE, 64'd0, 16'sd0, 8'sd0, KIND_EXACT, 8'sd0, 16'sd0, 16'sd0));

        key_pool.push_back(K_TOP);
        key_pool.push_back(K_LOW);
        key_pool.push_back(K_UP);
        key_pool.push_back(K_ODD);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            it = random_cmd();
            if (it.cmd != CMD_NOP)
                sent++;
            quiet = (sent >= RANDOM_ITEMS - QUIET_TAIL);
            push_cmd(it);
        end
        s_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
